// ===== src/mkwc_pkg.sv =====
`timescale 1ns / 1ps

package mkwc_pkg;

    // keyword store geometry
    localparam int NUM_KEYWORDS = 16;
    localparam int MAX_WORD_LEN = 32;

    localparam int IDX_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam int POS_W = $clog2(MAX_WORD_LEN);

    // stream widths
    localparam int S_TUSER_W = 3;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int COUNT_W   = 32;

    // item kinds carried in s_tuser
    localparam logic [2:0] MODE_LOAD  = 3'd0;
    localparam logic [2:0] MODE_TEXT  = 3'd1;
    localparam logic [2:0] MODE_END   = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

endpackage

// ===== src/mkwc_ram.sv =====
`timescale 1ns / 1ps

// single write port, registered read, new data on address collision
module mkwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/multi_keyword_word_counter.sv =====
`timescale 1ns / 1ps

// Keyword word-frequency counter. Text bytes are cut into words of ASCII
// letters; any other text byte or an end-of-text word closes the current
// word, which is matched against up to NUM_KEYWORDS stored keywords (exact
// or case-insensitive per the case-fold register, lengths must agree). Every
// matching keyword bumps its own saturating 32-bit count. The block takes one
// word per cycle while the output is not stalled and returns exactly one
// result word per input word, which passes through the input register and then
// the result register. Throughput is set by the letter compare, which
// reads one byte from each keyword's store in parallel; every keyword has its
// own small RAM whose read address is the next word position, so the byte
// for the following letter is already registered when that letter arrives.
// No clearing pass runs after reset: keyword bytes are undefined until
// loaded, lengths reset to zero (keyword off), counts to zero.
module multi_keyword_word_counter (
    input  logic                           aclk,
    input  logic                           aresetn,

    // config: bit 0 case fold enable
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode[2:0]
    input  logic [mkwc_pkg::S_TUSER_W-1:0] s_tuser,
    // word_index[3:0], char_pos[8:4], data_byte[16:9], zero fill
    input  logic [mkwc_pkg::S_TDATA_W-1:0] s_tdata,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // word_ended[0], hit[1], hit_index[5:2], count_value[37:6], zero fill
    output logic [mkwc_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int NK    = mkwc_pkg::NUM_KEYWORDS;
    localparam int IDX_W = mkwc_pkg::IDX_W;
    localparam int POS_W = mkwc_pkg::POS_W;
    localparam int CW    = mkwc_pkg::COUNT_W;

    // input register
    logic             in_valid_reg;
    logic [2:0]       in_mode_reg;
    logic [3:0]       in_index_reg;
    logic [4:0]       in_pos_reg;
    logic [7:0]       in_byte_reg;

    // result register
    logic             out_valid_reg;
    logic             out_ended_reg;
    logic             out_hit_reg;
    logic [3:0]       out_hit_index_reg;
    logic [CW-1:0]    out_count_reg;

    // block state
    logic             nocase_reg;
    logic [POS_W-1:0] kw_len_reg [NK];
    logic [POS_W-1:0] kw_len_next [NK];
    logic [NK-1:0]    alive_reg, alive_next;
    logic [POS_W-1:0] word_pos_reg, word_pos_next;
    logic             too_long_reg, too_long_next;
    logic [CW-1:0]    count_reg [NK];
    logic [CW-1:0]    count_next [NK];

    // result of the current item
    logic             ended_next;
    logic             hit_next;
    logic [3:0]       hit_index_next;
    logic [CW-1:0]    count_value_next;

    logic             fire;
    logic [IDX_W-1:0] slot;
    logic             slot_ok;
    logic             pos_ok;
    logic [POS_W-1:0] load_pos;
    logic [7:0]       kw_byte [NK];
    logic [NK-1:0]    kw_wr_en;
    logic [NK-1:0]    match;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        if (ic && (c inside {[8'h41:8'h5A]})) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // handshakes: the input register moves on whenever the result register
    // is empty or being drained
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    assign slot     = IDX_W'(in_index_reg);
    assign slot_ok  = int'(in_index_reg) < NK;
    assign pos_ok   = int'(in_pos_reg) < mkwc_pkg::MAX_WORD_LEN;
    assign load_pos = POS_W'(in_pos_reg);

    // one byte store per keyword, read at the position of the next letter
    for (genvar k = 0; k < NK; k++) begin : g_kw
        assign kw_wr_en[k] = fire && (in_mode_reg == mkwc_pkg::MODE_LOAD) &&
                             slot_ok && pos_ok && (in_byte_reg != 8'd0) &&
                             (slot == IDX_W'(k));

        mkwc_ram #(
            .WIDTH (8),
            .DEPTH (mkwc_pkg::MAX_WORD_LEN)
        ) u_kw_ram (
            .aclk    (aclk),
            .wr_en   (kw_wr_en[k]),
            .wr_addr (load_pos),
            .wr_data (in_byte_reg),
            .rd_addr (word_pos_next),
            .rd_data (kw_byte[k])
        );

        // closing match: still alive, enabled, same length
        assign match[k] = alive_reg[k] && (kw_len_reg[k] != '0) &&
                          (kw_len_reg[k] == word_pos_reg);
    end

    // single-pass item processing
    always_comb begin
        kw_len_next      = kw_len_reg;
        count_next       = count_reg;
        alive_next       = alive_reg;
        word_pos_next    = word_pos_reg;
        too_long_next    = too_long_reg;
        ended_next       = 1'b0;
        hit_next         = 1'b0;
        hit_index_next   = 4'd0;
        count_value_next = '0;

        if (fire) begin
            case (in_mode_reg)
                mkwc_pkg::MODE_LOAD: begin
                    if (slot_ok && pos_ok && (in_byte_reg == 8'd0)) begin
                        kw_len_next[slot] = load_pos;
                    end
                end
                mkwc_pkg::MODE_TEXT, mkwc_pkg::MODE_END: begin
                    if ((in_mode_reg == mkwc_pkg::MODE_TEXT) && is_letter(in_byte_reg)) begin
                        // take a letter
                        if (!too_long_reg) begin
                            if (word_pos_reg == POS_W'(mkwc_pkg::MAX_WORD_LEN - 1)) begin
                                too_long_next = 1'b1;
                            end else begin
                                for (int k = 0; k < NK; k++) begin
                                    if (fold(kw_byte[k], nocase_reg) !=
                                        fold(in_byte_reg, nocase_reg)) begin
                                        alive_next[k] = 1'b0;
                                    end
                                end
                                word_pos_next = word_pos_reg + POS_W'(1);
                            end
                        end
                    end else if ((word_pos_reg != '0) || too_long_reg) begin
                        // close a nonempty word
                        ended_next = 1'b1;
                        if (!too_long_reg) begin
                            for (int k = NK - 1; k >= 0; k--) begin
                                if (match[k]) begin
                                    hit_next       = 1'b1;
                                    hit_index_next = 4'(k);
                                    if (count_reg[k] != {CW{1'b1}}) begin
                                        count_next[k] = count_reg[k] + CW'(1);
                                    end
                                end
                            end
                        end
                        alive_next    = '1;
                        word_pos_next = '0;
                        too_long_next = 1'b0;
                    end
                end
                mkwc_pkg::MODE_READ: begin
                    if (slot_ok) begin
                        count_value_next = count_reg[slot];
                    end
                end
                mkwc_pkg::MODE_CLEAR: begin
                    for (int k = 0; k < NK; k++) begin
                        count_next[k] = '0;
                    end
                    alive_next    = '1;
                    word_pos_next = '0;
                    too_long_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            nocase_reg      <= 1'b1;
            alive_reg       <= '1;
            word_pos_reg    <= '0;
            too_long_reg    <= 1'b0;
            for (int k = 0; k < NK; k++) begin
                kw_len_reg[k] <= '0;
                count_reg[k]  <= '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                nocase_reg <= cfg_data;
            end
            alive_reg    <= alive_next;
            word_pos_reg <= word_pos_next;
            too_long_reg <= too_long_next;
            kw_len_reg   <= kw_len_next;
            count_reg    <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg  <= s_tuser[2:0];
            in_index_reg <= s_tdata[3:0];
            in_pos_reg   <= s_tdata[8:4];
            in_byte_reg  <= s_tdata[16:9];
        end
        if (fire) begin
            out_ended_reg     <= ended_next;
            out_hit_reg       <= hit_next;
            out_hit_index_reg <= hit_index_next;
            out_count_reg     <= count_value_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_hit_index_reg, out_hit_reg, out_ended_reg};

endmodule

// ===== src/mkwc_checker.sv =====
`timescale 1ns / 1ps

module mkwc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mkwc_pkg::M_TDATA_W-1:0] m_tdata
);

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a hit needs a closed word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("hit without word end");

    // hit index is zero unless there was a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[5:2] == 4'd0)
        else $error("hit index set without hit");

    // word closings never carry a count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[37:6] == 32'd0)
        else $error("count on a word close result");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind multi_keyword_word_counter mkwc_checker u_mkwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int NUM_KEYWORDS = mkwc_pkg::NUM_KEYWORDS;
    localparam int MAX_WORD_LEN = mkwc_pkg::MAX_WORD_LEN;
    localparam int S_TUSER_W    = mkwc_pkg::S_TUSER_W;
    localparam int S_TDATA_W    = mkwc_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = mkwc_pkg::M_TDATA_W;

    // one word on the input stream, plus a flag that makes the sender
    // hold it back until every result already owed has come out
    typedef struct packed {
        bit [2:0] mode;
        bit [3:0] widx;
        bit [4:0] pos;
        bit [7:0] data;
        bit       hold;
    } text_item_t;

    typedef struct packed {
        bit        ended;
        bit        hit;
        bit [3:0]  hit_idx;
        bit [31:0] count;
    } tally_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_data  = 1'b0;
    logic                 cfg_ready;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    multi_keyword_word_counter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predicted state of the counter
    bit [7:0]  kw_char [NUM_KEYWORDS][MAX_WORD_LEN];
    bit [5:0]  kw_len  [NUM_KEYWORDS];
    bit [31:0] hits    [NUM_KEYWORDS];
    bit [NUM_KEYWORDS-1:0] alive = '1;
    bit [5:0]  word_len  = '0;
    bit        word_long = 1'b0;
    bit        nocase    = 1'b1;

    // what the stimulus side believes the keywords are, used only to pick words
    bit [7:0]  kw_shadow     [NUM_KEYWORDS][MAX_WORD_LEN];
    int        kw_shadow_len [NUM_KEYWORDS];

    text_item_t item_queue [$];
    tally_t     tallies_due [$];
    text_item_t cur_item;

    bit idle_on   = 1'b1;
    bit hold_next = 1'b0;
    int gap_left   = 0;
    int stall_left = 0;
    int quiet      = 0;
    int n_queued   = 0;
    int n_taken    = 0;
    int n_results  = 0;
    int n_hits     = 0;
    int cfg_writes = 0;
    int errors     = 0;

    function automatic bit is_letter(input bit [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit [7:0] fold_case(input bit [7:0] c);
        if (nocase && c >= "A" && c <= "Z")
            return c + 8'd32;
        return c;
    endfunction

    task automatic drop_word();
        alive     = '1;
        word_len  = '0;
        word_long = 1'b0;
    endtask

    task automatic close_word(inout tally_t r);
        bit any;
        any = 1'b0;
        if (word_len == 0 && !word_long)
            return;
        r.ended = 1'b1;
        if (!word_long) begin
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                if (alive[k] && kw_len[k] != 0 && kw_len[k] == word_len) begin
                    if (hits[k] != 32'hFFFF_FFFF)
                        hits[k]++;
                    if (!any)
                        r.hit_idx = 4'(k);
                    any = 1'b1;
                end
            end
        end
        r.hit = any;
        drop_word();
    endtask

    // expected result of one accepted word, with the state update it causes
    task automatic tally_item(input text_item_t it, output tally_t r);
        r = '0;
        case (it.mode)
            mkwc_pkg::MODE_LOAD: begin
                if (it.data == 8'd0)
                    kw_len[it.widx] = 6'(it.pos);
                else
                    kw_char[it.widx][it.pos] = it.data;
            end
            mkwc_pkg::MODE_TEXT: begin
                if (!is_letter(it.data)) begin
                    close_word(r);
                end else if (!word_long) begin
                    if (word_len >= MAX_WORD_LEN - 1) begin
                        word_long = 1'b1;
                    end else begin
                        for (int k = 0; k < NUM_KEYWORDS; k++)
                            if (fold_case(kw_char[k][word_len]) != fold_case(it.data))
                                alive[k] = 1'b0;
                        word_len++;
                    end
                end
            end
            mkwc_pkg::MODE_END: close_word(r);
            mkwc_pkg::MODE_READ: r.count = hits[it.widx];
            mkwc_pkg::MODE_CLEAR: begin
                for (int k = 0; k < NUM_KEYWORDS; k++)
                    hits[k] = '0;
                drop_word();
            end
            default: ;
        endcase
    endtask

    // sender: presents queued words, holds them under backpressure, idles in bursts
    always @(posedge aclk) begin : drive_items
        text_item_t nxt;
        tally_t     r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tally_item(cur_item, r);
                tallies_due.push_back(r);
                n_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (item_queue.size() == 0 ||
                             (item_queue[0].hold && tallies_due.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 8);
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = item_queue.pop_front();
                    cur_item = nxt;
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.mode;
                    s_tdata  <= {{(S_TDATA_W - 17){1'b0}}, nxt.data, nxt.pos, nxt.widx};
                end
            end
        end
    end

    task automatic check_field(input string name, input bit [31:0] want, input bit [31:0] got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // receiver: checks every result word against the oldest prediction
    always @(posedge aclk) begin : watch_results
        tally_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (m_tdata[1])
                    n_hits++;
                if (tallies_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = tallies_due.pop_front();
                    check_field("word_ended", 32'(want.ended), 32'(m_tdata[0]));
                    check_field("hit", 32'(want.hit), 32'(m_tdata[1]));
                    check_field("hit_index", 32'(want.hit_idx), 32'(m_tdata[5:2]));
                    check_field("count_value", want.count, m_tdata[37:6]);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_item(input bit [2:0] mode, input bit [3:0] widx,
                            input bit [4:0] pos, input bit [7:0] data);
        item_queue.push_back('{mode, widx, pos, data, hold_next});
        hold_next = 1'b0;
        n_queued++;
    endtask

    task automatic add_text_byte(input bit [7:0] c);
        add_item(mkwc_pkg::MODE_TEXT, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)), c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_text_byte(s[i]);
    endtask

    task automatic set_kw(input int slot, input int pos, input bit [7:0] c);
        add_item(mkwc_pkg::MODE_LOAD, 4'(slot), 5'(pos), c);
        if (c == 8'd0)
            kw_shadow_len[slot] = pos;
        else
            kw_shadow[slot][pos] = c;
    endtask

    task automatic load_keyword(input int slot, input string s);
        for (int i = 0; i < s.len(); i++)
            set_kw(slot, i, s[i]);
        set_kw(slot, s.len(), 8'd0);
    endtask

    task automatic load_random_keyword(input int slot, input int len);
        for (int i = 0; i < len; i++)
            set_kw(slot, i, 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "a" : "A"));
        set_kw(slot, len, 8'd0);
    endtask

    task automatic add_random_item();
        int sel, k, n;
        bit [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            // a word, most often some keyword in mixed case, then its terminator
            k = $urandom_range(0, NUM_KEYWORDS - 1);
            if ($urandom_range(0, 3) != 0 && kw_shadow_len[k] != 0) begin
                for (int i = 0; i < kw_shadow_len[k]; i++) begin
                    c = kw_shadow[k][i];
                    if (is_letter(c) && $urandom_range(0, 1))
                        c = c ^ 8'h20;
                    add_text_byte(c);
                end
            end else begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    add_text_byte(8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "a" : "A"));
            end
            if ($urandom_range(0, 9) == 0) begin
                add_item(mkwc_pkg::MODE_END, 4'($urandom_range(0, 15)),
                         5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
            end else begin
                do c = 8'($urandom_range(0, 255)); while (is_letter(c));
                add_text_byte(c);
            end
        end else if (sel < 68) begin
            add_item(mkwc_pkg::MODE_END, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                     8'($urandom_range(0, 255)));
        end else if (sel < 76) begin
            add_item(mkwc_pkg::MODE_READ, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                     8'($urandom_range(0, 255)));
        end else if (sel < 80) begin
            add_item(mkwc_pkg::MODE_CLEAR, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                     8'($urandom_range(0, 255)));
        end else if (sel < 86) begin
            load_random_keyword($urandom_range(0, NUM_KEYWORDS - 1),
                                ($urandom_range(0, 9) == 0) ? MAX_WORD_LEN - 1
                                                            : $urandom_range(1, 8));
        end else if (sel < 92) begin
            set_kw($urandom_range(0, NUM_KEYWORDS - 1), $urandom_range(0, MAX_WORD_LEN - 1),
                   ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
        end else if (sel < 96) begin
            add_item(3'($urandom_range(5, 7)), 4'($urandom_range(0, 15)),
                     5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
        end else begin
            // fully random word: any mode, any field
            add_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                     5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int count, input int hold_at);
        int start, step;
        start = n_queued;
        step  = 0;
        while (n_queued - start < count) begin
            if (step == hold_at)
                hold_next = 1'b1;
            add_random_item();
            step++;
        end
    endtask

    task automatic finish_phase();
        do @(posedge aclk); while (n_taken != n_queued || tallies_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_case_mode(input bit v);
        @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        nocase = v;
        cfg_writes++;
    endtask

    initial begin : run_phases
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        write_case_mode(1'b1);

        // every keyword byte gets a defined value before any letter is compared
        for (int k = 0; k < NUM_KEYWORDS; k++)
            for (int p = 0; p < MAX_WORD_LEN; p++)
                set_kw(k, p, 8'($urandom_range(1, 255)));

        load_keyword(0, "the");
        load_keyword(1, "The");
        load_keyword(2, "a");
        load_keyword(3, "abcdefghijklmnopqrstuvwxyzabcde");
        load_keyword(4, "word");
        set_kw(4, 0, 8'd0);                       // slot 4 switched off again
        load_keyword(15, "Zz");
        for (int k = 5; k < 15; k++)
            load_random_keyword(k, $urandom_range(1, 8));

        // directed text: folding, duplicates, longest and too-long words
        add_text("the The THE a ");
        add_text("ABCDEFGHIJKLMNOPQRSTUVWXYZABCDE ");
        add_text("abcdefghijklmnopqrstuvwxyzabcdef@");
        add_text("zZ");
        add_item(mkwc_pkg::MODE_END, 4'd15, 5'd31, 8'hFF);   // end closes an open word
        add_item(mkwc_pkg::MODE_END, 4'd0, 5'd0, 8'h00);     // end with nothing open
        add_text_byte(8'h00);
        add_text_byte(8'hFF);
        add_text("[`{\x7f");
        add_text("word ");                         // disabled slot never hits
        add_item(mkwc_pkg::MODE_READ, 4'd0, 5'd0, 8'h00);
        add_item(mkwc_pkg::MODE_READ, 4'd15, 5'd31, 8'hFF);
        add_item(3'd5, 4'd15, 5'd31, 8'hFF);
        add_item(3'd6, 4'd0, 5'd0, 8'h00);
        add_item(3'd7, 4'd10, 5'd21, 8'hAA);
        // keyword rewritten in the middle of a word
        add_text("th");
        set_kw(0, 2, "x");
        add_item(mkwc_pkg::MODE_READ, 4'd1, 5'd0, 8'h00);    // read leaves the word alone
        add_text("x.");
        set_kw(0, 2, "e");
        // clear drops the half-built word
        add_text("th");
        add_item(mkwc_pkg::MODE_CLEAR, 4'd0, 5'd0, 8'h00);
        add_text("e ");
        add_item(mkwc_pkg::MODE_READ, 4'd0, 5'd0, 8'h00);
        finish_phase();

        run_random(160, 30);
        finish_phase();

        write_case_mode(1'b0);
        run_random(140, 50);
        finish_phase();

        // last stretch runs with both sides at full rate
        write_case_mode(1'b1);
        idle_on = 1'b0;
        run_random(100, -1);
        finish_phase();

        $display("run: %0d input words, %0d results, %0d keyword hits", n_queued, n_results,
                 n_hits);
        $display("run: %0d case-mode writes, both exact and folded compare", cfg_writes);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
